[hdl/lbo_pkg.sv]
// lbo_pkg: shared types and constants for the label boundary overlay block
// no dependencies; imported by every module of the block

package lbo_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_LABEL_BITS = 16;

    localparam int IN_LABEL_W  = 16;
    localparam int CHANNEL_W   = 8;
    localparam int COLOUR_BITS = 3 * CHANNEL_W;
    localparam int S_TDATA_W   = IN_LABEL_W + COLOUR_BITS;
    localparam int M_TDATA_W   = COLOUR_BITS;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int FRAME_W_W   = 11;

    localparam logic [FRAME_W_W-1:0] RST_FRAME_WIDTH   = 11'd640;
    localparam logic [CHANNEL_W-1:0] RST_OVERLAY_BLUE  = 8'd0;
    localparam logic [CHANNEL_W-1:0] RST_OVERLAY_GREEN = 8'd0;
    localparam logic [CHANNEL_W-1:0] RST_OVERLAY_RED   = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_OVERLAY_BLUE  = 2'd1,
        REG_OVERLAY_GREEN = 2'd2,
        REG_OVERLAY_RED   = 2'd3
    } cfg_reg_t;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

endpackage

[hdl/lbo_line_store.sv]
// lbo_line_store: label and colour line memories with registered reads
// depends on lbo_pkg; forwards a write that lands on the entry being read

module lbo_line_store #(
    parameter int DEPTH      = lbo_pkg::DEF_MAX_WIDTH,
    parameter int LABEL_BITS = lbo_pkg::DEF_LABEL_BITS
) (
    input  logic                             aclk,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_centre_addr,
    input  logic [$clog2(DEPTH)-1:0]         rd_right_addr,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [LABEL_BITS-1:0]            wr_label,
    input  logic [lbo_pkg::COLOUR_BITS-1:0]  wr_colour,
    input  logic [LABEL_BITS-1:0]            wr_upper,
    output logic [LABEL_BITS-1:0]            centre_label,
    output logic [LABEL_BITS-1:0]            right_label,
    output logic [LABEL_BITS-1:0]            upper_label,
    output logic [lbo_pkg::COLOUR_BITS-1:0]  centre_colour
);
    import lbo_pkg::*;

    localparam int WORD_W = LABEL_BITS + COLOUR_BITS;

    // middle row: colour above label in one word, upper row: label only
    logic [WORD_W-1:0]     mid_mem [DEPTH];
    logic [LABEL_BITS-1:0] up_mem  [DEPTH];

    logic [WORD_W-1:0]     mid_centre_reg;
    logic [WORD_W-1:0]     mid_right_reg;
    logic [LABEL_BITS-1:0] up_reg;
    logic                  fwd_centre_reg;
    logic                  fwd_right_reg;
    logic [WORD_W-1:0]     fwd_word_reg;
    logic [LABEL_BITS-1:0] fwd_upper_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mid_mem[wr_addr] <= {wr_colour, wr_label};
            up_mem[wr_addr]  <= wr_upper;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mid_centre_reg <= mid_mem[rd_centre_addr];
            mid_right_reg  <= mid_mem[rd_right_addr];
            up_reg         <= up_mem[rd_centre_addr];
            // the array still returns the old word when written at the same edge
            fwd_centre_reg <= wr_en && (wr_addr == rd_centre_addr);
            fwd_right_reg  <= wr_en && (wr_addr == rd_right_addr);
            fwd_word_reg   <= {wr_colour, wr_label};
            fwd_upper_reg  <= wr_upper;
        end
    end

    logic [WORD_W-1:0] centre_word;
    logic [WORD_W-1:0] right_word;

    always_comb begin
        centre_word   = fwd_centre_reg ? fwd_word_reg : mid_centre_reg;
        right_word    = fwd_right_reg  ? fwd_word_reg : mid_right_reg;
        centre_label  = centre_word[LABEL_BITS-1:0];
        centre_colour = centre_word[WORD_W-1:LABEL_BITS];
        right_label   = right_word[LABEL_BITS-1:0];
        upper_label   = fwd_centre_reg ? fwd_upper_reg : up_reg;
    end

endmodule

[hdl/label_boundary_overlay_top.sv]
// label_boundary_overlay_top: 4-neighbour label boundary overlay on a pixel stream
// depends on lbo_pkg and lbo_line_store
//
//  channel  | direction | handshake        | contents
//  s_       | in        | tvalid / tready  | tuser mode, tdata label + bgr colour
//  m_       | out       | tvalid / tready  | tdata bgr colour, tuser boundary, tlast frame end
//  cfg_     | in        | wr_en only       | frame width and overlay colour by index
//
// one item per cycle unless a finished result waits on m_tready; a result passes
// the registered line-store read and then the output register
// results of a row appear while the next row (or its drain ticks) comes in
// reset clears counters and handshake state; line stores are not cleared
// the input stalls only while a finished result waits on m_tready

module label_boundary_overlay_top #(
    parameter int MAX_WIDTH  = lbo_pkg::DEF_MAX_WIDTH,
    parameter int LABEL_BITS = lbo_pkg::DEF_LABEL_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lbo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lbo_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // region_label[15:0], pixel_blue[23:16], pixel_green[31:24], pixel_red[39:32]
    input  logic [lbo_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_blue[7:0], out_green[15:8], out_red[23:16]
    output logic [lbo_pkg::M_TDATA_W-1:0]   m_tdata,
    // on_boundary[0]
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import lbo_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    // configuration registers
    logic [FRAME_W_W-1:0] frame_width_reg;
    logic [CHANNEL_W-1:0] ov_blue_reg;
    logic [CHANNEL_W-1:0] ov_green_reg;
    logic [CHANNEL_W-1:0] ov_red_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= RST_FRAME_WIDTH;
            ov_blue_reg     <= RST_OVERLAY_BLUE;
            ov_green_reg    <= RST_OVERLAY_GREEN;
            ov_red_reg      <= RST_OVERLAY_RED;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:   frame_width_reg <= cfg_wdata[FRAME_W_W-1:0];
                REG_OVERLAY_BLUE:  ov_blue_reg     <= cfg_wdata[CHANNEL_W-1:0];
                REG_OVERLAY_GREEN: ov_green_reg    <= cfg_wdata[CHANNEL_W-1:0];
                REG_OVERLAY_RED:   ov_red_reg      <= cfg_wdata[CHANNEL_W-1:0];
                default: ;
            endcase
        end
    end

    logic [WW-1:0] width_eff;

    always_comb begin
        if (frame_width_reg == '0) begin
            width_eff = WW'(1);
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(frame_width_reg);
        end
    end

    // input unpacking
    logic [LABEL_BITS-1:0]  in_label;
    logic [COLOUR_BITS-1:0] in_colour;
    logic                   in_is_drain;

    assign in_label    = LABEL_BITS'(s_tdata[IN_LABEL_W-1:0]);
    assign in_colour   = s_tdata[S_TDATA_W-1:IN_LABEL_W];
    assign in_is_drain = (s_tuser == MODE_DRAIN);

    // raster position
    logic [AW-1:0] col_reg, col_next;
    logic [1:0]    rows_reg, rows_next;
    logic [AW-1:0] drain_pos_reg, drain_pos_next;

    logic          restart_pix;
    logic [AW-1:0] col_eff;
    logic [1:0]    rows_eff;
    logic          drain_go;
    logic [AW-1:0] cur_c;
    logic [WW-1:0] c_inc;
    logic          row_end;
    logic [AW-1:0] right_c;
    logic          accept;
    logic          load;

    // stage 1: store data arrives, boundary is decided, row is written back
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_emit_reg;
    logic                   s1_pix_reg;
    logic [AW-1:0]          s1_c_reg;
    logic                   s1_first_col_reg;
    logic                   s1_top_ok_reg;
    logic                   s1_last_reg;
    logic [LABEL_BITS-1:0]  s1_label_reg;
    logic [COLOUR_BITS-1:0] s1_colour_reg;
    logic [LABEL_BITS-1:0]  left_hold_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg;
    logic                   m_boundary_reg;
    logic                   m_last_reg;

    logic                   out_ready;
    logic                   s1_adv;
    logic                   wr_en;
    logic                   out_load;

    logic [LABEL_BITS-1:0]  st_centre;
    logic [LABEL_BITS-1:0]  st_right;
    logic [LABEL_BITS-1:0]  st_upper;
    logic [COLOUR_BITS-1:0] st_colour;
    logic [LABEL_BITS-1:0]  nb_left;
    logic [LABEL_BITS-1:0]  nb_top;
    logic [LABEL_BITS-1:0]  nb_bottom;
    logic                   boundary;

    assign out_ready = !m_valid_reg || m_tready;
    assign s1_adv    = !s1_emit_reg || out_ready;
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        // a pixel arriving mid drain abandons it and opens a new frame
        restart_pix = !in_is_drain && (drain_pos_reg != '0);
        col_eff     = restart_pix ? '0 : col_reg;
        rows_eff    = restart_pix ? 2'd0 : rows_reg;
        drain_go    = in_is_drain && (rows_reg != 2'd0) && (col_reg == '0);
        cur_c       = in_is_drain ? drain_pos_reg : col_eff;
        c_inc       = WW'(cur_c) + WW'(1);
        row_end     = !(c_inc < width_eff);
        right_c     = row_end ? cur_c : AW'(c_inc);
        load        = accept && (!in_is_drain || drain_go);
    end

    always_comb begin
        col_next       = col_reg;
        rows_next      = rows_reg;
        drain_pos_next = drain_pos_reg;
        if (accept) begin
            if (!in_is_drain) begin
                drain_pos_next = '0;
                col_next       = row_end ? '0 : AW'(c_inc);
                rows_next      = rows_eff;
                if (row_end && (rows_eff != 2'd2)) begin
                    rows_next = rows_eff + 2'd1;
                end
            end else if (drain_go) begin
                if (row_end) begin
                    col_next       = '0;
                    rows_next      = 2'd0;
                    drain_pos_next = '0;
                end else begin
                    drain_pos_next = AW'(c_inc);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            rows_reg      <= 2'd0;
            drain_pos_reg <= '0;
        end else begin
            col_reg       <= col_next;
            rows_reg      <= rows_next;
            drain_pos_reg <= drain_pos_next;
        end
    end

    lbo_line_store #(
        .DEPTH      (MAX_WIDTH),
        .LABEL_BITS (LABEL_BITS)
    ) u_store (
        .aclk           (aclk),
        .rd_en          (load),
        .rd_centre_addr (cur_c),
        .rd_right_addr  (right_c),
        .wr_en          (wr_en),
        .wr_addr        (s1_c_reg),
        .wr_label       (s1_label_reg),
        .wr_colour      (s1_colour_reg),
        .wr_upper       (st_centre),
        .centre_label   (st_centre),
        .right_label    (st_right),
        .upper_label    (st_upper),
        .centre_colour  (st_colour)
    );

    always_comb begin
        nb_left   = s1_first_col_reg ? st_centre : left_hold_reg;
        nb_top    = s1_top_ok_reg ? st_upper : st_centre;
        // drain ticks stand on the bottom row, which replicates itself
        nb_bottom = s1_pix_reg ? s1_label_reg : st_centre;
        boundary  = (st_centre != nb_left) || (st_centre != st_right) ||
                    (st_centre != nb_top) || (st_centre != nb_bottom);
        wr_en     = s1_valid_reg && s1_pix_reg && s1_adv;
        out_load  = s1_valid_reg && s1_emit_reg && out_ready;
    end

    always_comb begin
        if (load) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            left_hold_reg <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s1_valid_reg && s1_adv) begin
                left_hold_reg <= st_centre;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_emit_reg      <= in_is_drain || (rows_eff != 2'd0);
            s1_pix_reg       <= !in_is_drain;
            s1_c_reg         <= cur_c;
            s1_first_col_reg <= (cur_c == '0);
            s1_top_ok_reg    <= in_is_drain ? (rows_reg == 2'd2) : (rows_eff == 2'd2);
            s1_last_reg      <= in_is_drain && row_end;
            s1_label_reg     <= in_label;
            s1_colour_reg    <= in_colour;
        end
        if (out_load) begin
            m_data_reg     <= boundary ? {ov_red_reg, ov_green_reg, ov_blue_reg} : st_colour;
            m_boundary_reg <= boundary;
            m_last_reg     <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_boundary_reg;
    assign m_tlast  = m_last_reg;

endmodule

[hdl/lbo_checker.sv]
// lbo_checker: port-level assertions for label_boundary_overlay_top
// depends on lbo_pkg; attached to the top level by the bind at the end

module lbo_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lbo_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);
    import lbo_pkg::*;

    // a stalled result keeps its contents
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // input is only held back by a result that cannot leave
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with free output");

    // a fresh result needs a source transaction ahead of stage 1 and the output register
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a source transaction");

endmodule

bind label_boundary_overlay_top lbo_checker u_lbo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[verif/label_boundary_overlay_top_test.sv]
// label_boundary_overlay_top_test: self-checking bench for label_boundary_overlay_top
// drives labelled pixel frames and drain ticks, predicts every overlay pixel, checks m_ side
// depends on lbo_pkg and the block's rtl
`timescale 1ns / 100ps

module label_boundary_overlay_top_test;
    import lbo_pkg::*;

    localparam int LINE_DEPTH  = DEF_MAX_WIDTH;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct packed {
        logic        mode;
        logic [15:0] label;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       boundary;
        logic       frame_end;
    } overlay_px_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // region_label[15:0], pixel_blue[23:16], pixel_green[31:24], pixel_red[39:32]
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    // mode[0]
    logic                   s_tuser   = MODE_PIXEL;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // out_blue[7:0], out_green[15:8], out_red[23:16]
    logic [M_TDATA_W-1:0]   m_tdata;
    // on_boundary[0]
    logic                   m_tuser;
    logic                   m_tlast;

    label_boundary_overlay_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    pixel_item_t pixel_stream_q[$];
    overlay_px_t overlay_pixels_due[$];
    pixel_item_t bus_item;
    bit          item_on_bus = 1'b0;
    int unsigned fail_count  = 0;
    int unsigned cyc         = 0;
    int unsigned quiet       = 0;
    int unsigned hold_left   = 0;
    bit          hold_done   = 1'b0;
    logic        steady;

    // both sides stop idling for a recurring stretch set by the cycle count
    assign steady = (cyc % 1500) >= 1000;

    // predictor state: line stores, raster position and register copies
    logic [15:0]          upper_labels [LINE_DEPTH];
    logic [15:0]          middle_labels[LINE_DEPTH];
    logic [23:0]          middle_colours[LINE_DEPTH];
    int unsigned          col_pos   = 0;
    int unsigned          rows_seen = 0;
    int unsigned          drain_pos = 0;
    logic [15:0]          left_label = '0;
    logic [FRAME_W_W-1:0] width_reg = RST_FRAME_WIDTH;
    logic [7:0]           ov_blue   = RST_OVERLAY_BLUE;
    logic [7:0]           ov_green  = RST_OVERLAY_GREEN;
    logic [7:0]           ov_red    = RST_OVERLAY_RED;

    // generator bookkeeping
    bit          frame_open   = 1'b0;
    int unsigned useful_items = 0;

    function automatic int unsigned active_width();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_DEPTH) return LINE_DEPTH;
        return width_reg;
    endfunction

    function automatic overlay_px_t paint(input logic [23:0] colour, input logic hit,
                                          input logic last);
        overlay_px_t px;
        px.blue      = hit ? ov_blue  : colour[7:0];
        px.green     = hit ? ov_green : colour[15:8];
        px.red       = hit ? ov_red   : colour[23:16];
        px.boundary  = hit;
        px.frame_end = last;
        return px;
    endfunction

    task automatic start_frame();
        col_pos    = 0;
        rows_seen  = 0;
        drain_pos  = 0;
        left_label = '0;
    endtask

    task automatic predict_boundary_pixel(input pixel_item_t it);
        int unsigned w, c, rc;
        logic [15:0] centre, left_n, right_n, top_n;
        logic        last;
        w = active_width();
        if (it.mode == MODE_PIXEL) begin
            if (drain_pos != 0) start_frame();
            c = col_pos;
            centre = middle_labels[c];
            if (rows_seen >= 1) begin
                left_n  = (c == 0) ? centre : left_label;
                rc      = (c + 1 < w) ? c + 1 : c;
                right_n = middle_labels[rc];
                top_n   = (rows_seen >= 2) ? upper_labels[c] : centre;
                overlay_pixels_due.push_back(paint(middle_colours[c],
                    centre != top_n || centre != left_n || centre != right_n ||
                    centre != it.label, 1'b0));
            end
            left_label        = centre;
            upper_labels[c]   = centre;
            middle_labels[c]  = it.label;
            middle_colours[c] = {it.red, it.green, it.blue};
            c++;
            if (c >= w) begin
                c = 0;
                if (rows_seen < 2) rows_seen++;
            end
            col_pos = c;
        end else if (rows_seen != 0 && col_pos == 0) begin
            // bottom row flush: the bottom neighbour is the pixel itself
            c       = drain_pos;
            centre  = middle_labels[c];
            left_n  = (c == 0) ? centre : middle_labels[c - 1];
            rc      = (c + 1 < w) ? c + 1 : c;
            right_n = middle_labels[rc];
            top_n   = (rows_seen >= 2) ? upper_labels[c] : centre;
            last    = (c + 1 >= w);
            overlay_pixels_due.push_back(paint(middle_colours[c],
                centre != top_n || centre != left_n || centre != right_n, last));
            if (last) start_frame();
            else drain_pos = c + 1;
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_boundary_pixel(bus_item);
                item_on_bus = 1'b0;
            end
            if (!item_on_bus) begin
                if (pixel_stream_q.size() != 0 && (steady || $urandom_range(0, 99) >= 11)) begin
                    bus_item    = pixel_stream_q.pop_front();
                    item_on_bus = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tuser  <= bus_item.mode;
                    s_tdata  <= {bus_item.red, bus_item.green, bus_item.blue, bus_item.label};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result monitor and receiver
    always @(posedge aclk) begin : sink
        overlay_px_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (overlay_pixels_due.size() == 0) begin
                    $error("unexpected transaction: tdata %h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    want = overlay_pixels_due.pop_front();
                    check_field("out_blue",    want.blue,          m_tdata[7:0]);
                    check_field("out_green",   want.green,         m_tdata[15:8]);
                    check_field("out_red",     want.red,           m_tdata[23:16]);
                    check_field("on_boundary", 8'(want.boundary),  8'(m_tuser));
                    check_field("frame_end",   8'(want.frame_end), 8'(m_tlast));
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!hold_done && m_tvalid && pixel_stream_q.size() > 16) begin
                // long back-pressure while the sender keeps offering
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= steady || $urandom_range(0, 99) >= 11;
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("label_boundary_overlay_top_test NOT OK");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:   width_reg = val;
            REG_OVERLAY_BLUE:  ov_blue   = val[7:0];
            REG_OVERLAY_GREEN: ov_green  = val[7:0];
            REG_OVERLAY_RED:   ov_red    = val[7:0];
            default: ;
        endcase
    endtask

    // idle: nothing queued, nothing on the bus, nothing outstanding
    task automatic wait_drained();
        while (pixel_stream_q.size() != 0 || item_on_bus || overlay_pixels_due.size() != 0)
            @(posedge aclk);
        // ignored drain ticks leave no result behind, give them time
        repeat (4) @(posedge aclk);
    endtask

    task automatic queue_pixel(input logic [15:0] label, input logic [7:0] b,
                               input logic [7:0] g, input logic [7:0] r);
        pixel_stream_q.push_back('{MODE_PIXEL, label, b, g, r});
    endtask

    task automatic queue_drain();
        pixel_stream_q.push_back('{MODE_DRAIN, 16'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom)});
    endtask

    function automatic logic [15:0] pick_label(input int unsigned span);
        case ($urandom_range(0, 19))
            0:       return 16'($urandom);
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, span));
        endcase
    endfunction

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // one frame of rows at width w, then a drain that may be cut short
    task automatic queue_frame(input int unsigned w, input int unsigned rows,
                               input bit full_drain, input int unsigned span);
        int unsigned r, x, cut;
        if (!frame_open && $urandom_range(0, 3) == 0) queue_drain();
        for (r = 0; r < rows; r++) begin
            for (x = 0; x < w; x++) begin
                if (x != 0 && $urandom_range(0, 15) == 0) queue_drain();
                queue_pixel(pick_label(span), 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        cut = full_drain ? w : $urandom_range(0, w - 1);
        repeat (cut) queue_drain();
        frame_open    = (cut < w);
        useful_items += rows * w + cut;
    endtask

    initial begin : stimulus
        int unsigned w, nframes, f;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // width 0 acts as one column; reset overlay colour
        write_reg(REG_FRAME_WIDTH, 11'd0);
        queue_drain();
        queue_pixel(16'h0000, 8'h00, 8'h00, 8'h00);
        queue_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        queue_pixel(16'hFFFF, 8'h12, 8'h34, 8'h56);
        queue_drain();
        wait_drained();

        // three columns: ignored mid-row drain, partial drain cut by a new frame
        write_reg(REG_FRAME_WIDTH, 11'd3);
        write_reg(REG_OVERLAY_BLUE, 11'd255);
        write_reg(REG_OVERLAY_GREEN, 11'd128);
        write_reg(REG_OVERLAY_RED, 11'd0);
        queue_pixel(16'd5, 8'h01, 8'h02, 8'h03);
        queue_pixel(16'd5, 8'h04, 8'h05, 8'h06);
        queue_pixel(16'd7, 8'h07, 8'h08, 8'h09);
        queue_pixel(16'd5, 8'hA0, 8'hA1, 8'hA2);
        queue_drain();
        queue_pixel(16'd5, 8'hB0, 8'hB1, 8'hB2);
        queue_pixel(16'd5, 8'hC0, 8'hC1, 8'hC2);
        queue_drain();
        queue_pixel(16'd9, 8'hD0, 8'hD1, 8'hD2);
        queue_pixel(16'd9, 8'hE0, 8'hE1, 8'hE2);
        queue_pixel(16'd9, 8'hF0, 8'hF1, 8'hF2);
        repeat (3) queue_drain();
        wait_drained();

        frame_open = 1'b0;
        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            write_reg(REG_FRAME_WIDTH, 11'(w));
            if ($urandom_range(0, 1)) write_reg(REG_OVERLAY_BLUE, 11'(pick_channel()));
            if ($urandom_range(0, 1)) write_reg(REG_OVERLAY_GREEN, 11'(pick_channel()));
            if ($urandom_range(0, 1)) write_reg(REG_OVERLAY_RED, 11'(pick_channel()));
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++)
                queue_frame(w, $urandom_range(1, 4),
                            (f == nframes - 1) || $urandom_range(0, 1), $urandom_range(0, 3));
            // the width only changes once the last frame is fully flushed
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("label_boundary_overlay_top_test OK");
        end else begin
            $display("label_boundary_overlay_top_test NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
hdl/lbo_pkg.sv
hdl/lbo_line_store.sv
hdl/label_boundary_overlay_top.sv
hdl/lbo_checker.sv
verif/label_boundary_overlay_top_test.sv
